/* src/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked only outside reset.
`define CMFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property checked at every clock edge, during reset as well.
`define CMFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cmfs_pkg.sv */
// Package of constants and types for the cube map face selection unit.
`timescale 1ns / 1ps

package cmfs_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int COORD_BITS     = 16;

  // Magnitude width, width of a signed minor component and of the divider remainder.
  localparam int MAG_W = COMPONENT_BITS;
  localparam int NUM_W = COMPONENT_BITS + 1;
  localparam int REM_W = MAG_W + 1;

  // Register stages from an accepted beat to its result strobe.
  localparam int LATENCY = COORD_BITS + 4;

  typedef enum logic [2:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_Z = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_Z = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Y = 3'd5
  } face_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    face_t            face;
    logic [MAG_W-1:0] major;
  } ctl_t;

endpackage

/* src/cube_map_face_select_unit.sv */
// Top level of the cube map face selection unit.
`timescale 1ns / 1ps

// Cube map face selection. Each beat carries one signed direction vector; the
// unit picks the face of the axis with the largest magnitude (x wins ties over
// y, y over z) and returns the two face coordinates floor((1 + minor/major) *
// 2^(COORD_BITS-1)), saturated to the coordinate range. An all-zero vector
// returns face 0, both coordinates at one half and zero_vector set. The unit
// accepts one beat every clock cycle and busy is never raised. Each result
// appears on the out_ ports for exactly one cycle, marked by out_valid, once
// its beat has passed the input, magnitude, dividend and divider stages; the
// restoring divider resolves one quotient bit per pipeline stage for each
// coordinate. The receiver cannot stall the unit, so every result must be
// taken in the cycle it is shown.
module cube_map_face_select_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_x,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_y,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_z,
  output logic                                  out_valid,
  output logic [2:0]                            out_face,
  output logic [cmfs_pkg::COORD_BITS-1:0]       out_s_coord,
  output logic [cmfs_pkg::COORD_BITS-1:0]       out_t_coord,
  output logic                                  out_zero_vector
);

  localparam int CB = cmfs_pkg::COMPONENT_BITS;
  localparam int QB = cmfs_pkg::COORD_BITS;
  localparam int MW = cmfs_pkg::MAG_W;
  localparam int NW = cmfs_pkg::NUM_W;
  localparam int RW = cmfs_pkg::REM_W;

  // The pipeline never stalls, so a beat is taken whenever start is high.
  assign busy = 1'b0;

  // Stage 1: input register.
  logic                 v1_r;
  logic signed [CB-1:0] x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    x1_r <= in_dir_x;
    y1_r <= in_dir_y;
    z1_r <= in_dir_z;
  end

  // Stage 2: magnitudes, major axis, face and signed minor numerators.
  logic signed [NW-1:0] xe, ye, ze;
  logic [MW-1:0]        ax, ay, az;
  cmfs_pkg::ctl_t       c2_nxt, c2_r;
  logic signed [NW-1:0] ns2_nxt, nt2_nxt, ns2_r, nt2_r;

  always_comb begin
    xe = NW'(x1_r);
    ye = NW'(y1_r);
    ze = NW'(z1_r);
    ax = MW'(xe < 0 ? -xe : xe);
    ay = MW'(ye < 0 ? -ye : ye);
    az = MW'(ze < 0 ? -ze : ze);
    c2_nxt.valid = v1_r;
    c2_nxt.zero  = (ax == '0) && (ay == '0) && (az == '0);
    if (ax >= ay && ax >= az) begin
      c2_nxt.face  = (xe >= 0) ? cmfs_pkg::FACE_POS_X : cmfs_pkg::FACE_NEG_X;
      c2_nxt.major = ax;
      ns2_nxt      = (xe >= 0) ? -ze : ze;
      nt2_nxt      = ye;
    end else if (ay >= az) begin
      // The y faces keep the swapped top and bottom numbering.
      c2_nxt.face  = (ye >= 0) ? cmfs_pkg::FACE_POS_Y : cmfs_pkg::FACE_NEG_Y;
      c2_nxt.major = ay;
      ns2_nxt      = xe;
      nt2_nxt      = (ye >= 0) ? -ze : ze;
    end else begin
      c2_nxt.face  = (ze >= 0) ? cmfs_pkg::FACE_POS_Z : cmfs_pkg::FACE_NEG_Z;
      c2_nxt.major = az;
      ns2_nxt      = (ze >= 0) ? xe : -xe;
      nt2_nxt      = ye;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.valid <= 1'b0;
    end else begin
      c2_r.valid <= c2_nxt.valid;
    end
    c2_r.zero  <= c2_nxt.zero;
    c2_r.face  <= c2_nxt.face;
    c2_r.major <= c2_nxt.major;
    ns2_r      <= ns2_nxt;
    nt2_r      <= nt2_nxt;
  end

  // Stage 3: dividends major + minor, clamped at zero. They never exceed twice
  // the major magnitude.
  logic signed [NW:0] sum_s, sum_t;
  logic [RW-1:0]      rs3_nxt, rt3_nxt, rs3_r, rt3_r;
  cmfs_pkg::ctl_t     c3_r;

  always_comb begin
    sum_s   = $signed({2'b00, c2_r.major}) + (NW+1)'(ns2_r);
    sum_t   = $signed({2'b00, c2_r.major}) + (NW+1)'(nt2_r);
    rs3_nxt = (sum_s < 0) ? '0 : RW'(sum_s);
    rt3_nxt = (sum_t < 0) ? '0 : RW'(sum_t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r.valid <= 1'b0;
    end else begin
      c3_r.valid <= c2_r.valid;
    end
    c3_r.zero  <= c2_r.zero;
    c3_r.face  <= c2_r.face;
    c3_r.major <= c2_r.major;
    rs3_r      <= rs3_nxt;
    rt3_r      <= rt3_nxt;
  end

  // Divider stages. Stage 0 resolves the quotient bit of weight 2^COORD_BITS,
  // which is set only for a ratio of exactly one. Each later stage resolves one
  // more bit against the major magnitude and doubles the remainder, which
  // always stays below twice the major magnitude.
  cmfs_pkg::ctl_t c_nxt  [0:QB];
  cmfs_pkg::ctl_t c_r    [0:QB];
  logic [RW-1:0]  rs_nxt [0:QB];
  logic [RW-1:0]  rt_nxt [0:QB];
  logic [RW-1:0]  rs_r   [0:QB];
  logic [RW-1:0]  rt_r   [0:QB];
  logic [QB:0]    qs_nxt [0:QB];
  logic [QB:0]    qt_nxt [0:QB];
  logic [QB:0]    qs_r   [0:QB];
  logic [QB:0]    qt_r   [0:QB];

  always_comb begin
    logic [RW-1:0] two_m;
    logic [RW-1:0] m_ext;
    logic          bs, bt;
    logic [RW-1:0] ds, dt;
    two_m     = {c3_r.major, 1'b0};
    c_nxt[0]  = c3_r;
    bs        = rs3_r >= two_m;
    bt        = rt3_r >= two_m;
    rs_nxt[0] = bs ? rs3_r - two_m : rs3_r;
    rt_nxt[0] = bt ? rt3_r - two_m : rt3_r;
    qs_nxt[0] = {{QB{1'b0}}, bs};
    qt_nxt[0] = {{QB{1'b0}}, bt};
    for (int k = 1; k <= QB; k++) begin
      m_ext     = {1'b0, c_r[k-1].major};
      c_nxt[k]  = c_r[k-1];
      bs        = rs_r[k-1] >= m_ext;
      bt        = rt_r[k-1] >= m_ext;
      ds        = bs ? rs_r[k-1] - m_ext : rs_r[k-1];
      dt        = bt ? rt_r[k-1] - m_ext : rt_r[k-1];
      rs_nxt[k] = {ds[RW-2:0], 1'b0};
      rt_nxt[k] = {dt[RW-2:0], 1'b0};
      qs_nxt[k] = {qs_r[k-1][QB-1:0], bs};
      qt_nxt[k] = {qt_r[k-1][QB-1:0], bt};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QB; k++) begin
      if (!rst_n) begin
        c_r[k].valid <= 1'b0;
      end else begin
        c_r[k].valid <= c_nxt[k].valid;
      end
      c_r[k].zero  <= c_nxt[k].zero;
      c_r[k].face  <= c_nxt[k].face;
      c_r[k].major <= c_nxt[k].major;
      rs_r[k]      <= rs_nxt[k];
      rt_r[k]      <= rt_nxt[k];
      qs_r[k]      <= qs_nxt[k];
      qt_r[k]      <= qt_nxt[k];
    end
  end

  // Result: a ratio of exactly one saturates to all ones; the zero vector
  // overrides everything with face 0 and both coordinates at one half.
  localparam logic [QB-1:0] HALF = {1'b1, {(QB-1){1'b0}}};

  assign out_valid       = c_r[QB].valid;
  assign out_zero_vector = c_r[QB].zero;
  assign out_face        = c_r[QB].zero ? 3'(cmfs_pkg::FACE_NEG_X) : 3'(c_r[QB].face);
  assign out_s_coord     = c_r[QB].zero ? HALF :
                           (qs_r[QB][QB] ? {QB{1'b1}} : qs_r[QB][QB-1:0]);
  assign out_t_coord     = c_r[QB].zero ? HALF :
                           (qt_r[QB][QB] ? {QB{1'b1}} : qt_r[QB][QB-1:0]);

endmodule

/* src/cmfs_checker.sv */
// Port-level checker for the cube map face selection unit, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmfs_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic [2:0]                            out_face,
  input logic [cmfs_pkg::COORD_BITS-1:0]       out_s_coord,
  input logic [cmfs_pkg::COORD_BITS-1:0]       out_t_coord,
  input logic                                  out_zero_vector
);

  localparam logic [cmfs_pkg::COORD_BITS-1:0] HALF =
    {1'b1, {(cmfs_pkg::COORD_BITS-1){1'b0}}};

  logic accepted;
  logic zero_ok;
  logic face_ok;

  assign accepted = start && !busy;
  assign zero_ok  = (out_face == 3'(cmfs_pkg::FACE_NEG_X)) &&
                    (out_s_coord == HALF) && (out_t_coord == HALF);
  assign face_ok  = out_face <= 3'(cmfs_pkg::FACE_NEG_Y);

  // The unit never holds off a beat.
  `CMFS_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

  // Every result strobe stems from a beat accepted a fixed latency earlier.
  `CMFS_ASSERT(a_latency, out_valid |-> $past(accepted, cmfs_pkg::LATENCY), "stray result")

  // A zero vector always reports face 0 and both coordinates at one half.
  `CMFS_ASSERT(a_zero, (out_valid && out_zero_vector) |-> zero_ok, "zero vector result wrong")

  // Faces are numbered 0 to 5 only.
  `CMFS_ASSERT(a_face, out_valid |-> face_ok, "face out of range")

endmodule

bind cube_map_face_select_unit cmfs_checker u_cmfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_face        (out_face),
  .out_s_coord     (out_s_coord),
  .out_t_coord     (out_t_coord),
  .out_zero_vector (out_zero_vector)
);
